// File: hw/rtl/maghead_pkg.sv
// Shared constants, types and the CORDIC angle table for the heading block.
`timescale 1ns / 1ps
package maghead_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int ACC_FRAC        = 16;
  localparam int CORDIC_STEPS    = 23;
  localparam int PRESHIFT        = 20;
  localparam int AXIS_W          = 16;
  localparam int SCALE_W         = 12;
  localparam int SCALED_W        = 28;
  localparam int HEAD_W          = 15;
  localparam int XY_W            = 40;
  localparam int ACC_W           = 26;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(236);

  localparam logic signed [ACC_W-1:0] HALF_TURN_ACC = ACC_W'(180 * (2 ** ACC_FRAC));
  localparam logic signed [ACC_W:0]   FULL_TURN_ACC = (ACC_W + 1)'(360 * (2 ** ACC_FRAC));
  localparam logic signed [ACC_W:0]   ROUND_HALF    =
    (ACC_W + 1)'(2 ** (ACC_FRAC - 1 - ANGLE_FRAC_BITS));
  localparam int                      ROUND_SHIFT   = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ACC_W:0]   FULL_TURN_OUT =
    (ACC_W + 1)'(360 * (2 ** ANGLE_FRAC_BITS));

  localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    ACC_W'(2949120), ACC_W'(1740967), ACC_W'(919879), ACC_W'(466945),
    ACC_W'(234379),  ACC_W'(117304),  ACC_W'(58666),  ACC_W'(29335),
    ACC_W'(14668),   ACC_W'(7334),    ACC_W'(3667),   ACC_W'(1833),
    ACC_W'(917),     ACC_W'(458),     ACC_W'(229),    ACC_W'(115),
    ACC_W'(57),      ACC_W'(29),      ACC_W'(14),     ACC_W'(7),
    ACC_W'(4),       ACC_W'(2),       ACC_W'(1)
  };

  typedef struct packed {
    logic signed [AXIS_W-1:0]   raw_x;
    logic signed [AXIS_W-1:0]   raw_y;
    logic signed [AXIS_W-1:0]   raw_z;
    logic signed [SCALED_W-1:0] scaled_x;
    logic signed [SCALED_W-1:0] scaled_y;
    logic signed [SCALED_W-1:0] scaled_z;
    logic                       zero;
  } side_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
  } cordic_t;

endpackage

// File: hw/rtl/magnetometer_heading.sv
// Magnetometer heading: six-byte burst in, raw and scaled axes plus heading out.
//
// Input channel in_*: one request carries the six burst bytes (X, Z, Y, high
// byte first). Output channel out_*: one result per request, in order, with
// raw counts, counts times the resolution (1/256 mG) and the heading in
// 1/64 degree, 0..23039, counterclockwise from X.
// Configuration channel cfg_*: writes the 12-bit Q4.8 resolution; always
// ready, takes effect for requests accepted after the write.
// Pipeline: an accepted request passes 25 register stages, the first loaded
// at the accepting edge: one input stage with the scaling multipliers, 23
// CORDIC stages of one rotation step each, one rounding and output register
// stage.
// Throughput: one request per cycle while out_ready is high; every stage
// holds its own valid bit, so bubbles close up while the output stalls.
// Reset: all stages empty, resolution back to 236.
// Stall: when out_ready is low the result holds, upstream stages keep
// filling, and in_ready drops only once every stage is occupied.
`timescale 1ns / 1ps
module magnetometer_heading (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_x_high,
  input  logic [7:0]                     in_x_low,
  input  logic [7:0]                     in_z_high,
  input  logic [7:0]                     in_z_low,
  input  logic [7:0]                     in_y_high,
  input  logic [7:0]                     in_y_low,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [maghead_pkg::SCALE_W-1:0] cfg_scale_q8,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [maghead_pkg::AXIS_W-1:0]   out_raw_x,
  output logic signed [maghead_pkg::AXIS_W-1:0]   out_raw_y,
  output logic signed [maghead_pkg::AXIS_W-1:0]   out_raw_z,
  output logic signed [maghead_pkg::SCALED_W-1:0] out_scaled_x,
  output logic signed [maghead_pkg::SCALED_W-1:0] out_scaled_y,
  output logic signed [maghead_pkg::SCALED_W-1:0] out_scaled_z,
  output logic [maghead_pkg::HEAD_W-1:0]          out_heading_deg
);
  import maghead_pkg::*;

  logic [SCALE_W-1:0] scale_r;
  logic               f_valid;
  logic               f_ready;
  side_t              f_side;
  cordic_t            f_cordic;
  logic               c_valid;
  logic               c_ready;
  side_t              c_side;
  cordic_t            c_cordic;
  side_t              o_side;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_valid) begin
      scale_r <= cfg_scale_q8;
    end
  end

  maghead_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .x_high     (in_x_high),
    .x_low      (in_x_low),
    .z_high     (in_z_high),
    .z_low      (in_z_low),
    .y_high     (in_y_high),
    .y_low      (in_y_low),
    .scale      (scale_r),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_side   (f_side),
    .out_cordic (f_cordic)
  );

  maghead_cordic u_cordic (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (f_valid),
    .in_ready   (f_ready),
    .in_side    (f_side),
    .in_cordic  (f_cordic),
    .out_valid  (c_valid),
    .out_ready  (c_ready),
    .out_side   (c_side),
    .out_cordic (c_cordic)
  );

  maghead_finish u_finish (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (c_valid),
    .in_ready    (c_ready),
    .in_side     (c_side),
    .in_cordic   (c_cordic),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_side    (o_side),
    .out_heading (out_heading_deg)
  );

  assign out_raw_x    = o_side.raw_x;
  assign out_raw_y    = o_side.raw_y;
  assign out_raw_z    = o_side.raw_z;
  assign out_scaled_x = o_side.scaled_x;
  assign out_scaled_y = o_side.scaled_y;
  assign out_scaled_z = o_side.scaled_z;

endmodule

// File: hw/rtl/maghead_front.sv
// Input stage: unpack the burst, scale the axes and seed the CORDIC vector.
`timescale 1ns / 1ps
module maghead_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     x_high,
  input  logic [7:0]                     x_low,
  input  logic [7:0]                     z_high,
  input  logic [7:0]                     z_low,
  input  logic [7:0]                     y_high,
  input  logic [7:0]                     y_low,
  input  logic [maghead_pkg::SCALE_W-1:0] scale,
  output logic                           out_valid,
  input  logic                           out_ready,
  output maghead_pkg::side_t             out_side,
  output maghead_pkg::cordic_t           out_cordic
);
  import maghead_pkg::*;

  logic                        valid_r;
  side_t                       side_r;
  side_t                       side_nxt;
  cordic_t                     cordic_r;
  cordic_t                     cordic_nxt;
  logic signed [AXIS_W-1:0]    rx;
  logic signed [AXIS_W-1:0]    ry;
  logic signed [AXIS_W-1:0]    rz;
  logic signed [SCALE_W:0]     scale_s;
  logic signed [AXIS_W+SCALE_W:0] px;
  logic signed [AXIS_W+SCALE_W:0] py;
  logic signed [AXIS_W+SCALE_W:0] pz;
  logic signed [AXIS_W:0]      x17;
  logic signed [AXIS_W:0]      y17;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    rx      = $signed({x_high, x_low});
    ry      = $signed({y_high, y_low});
    rz      = $signed({z_high, z_low});
    scale_s = $signed({1'b0, scale});
    px      = rx * scale_s;
    py      = ry * scale_s;
    pz      = rz * scale_s;
    side_nxt.raw_x    = rx;
    side_nxt.raw_y    = ry;
    side_nxt.raw_z    = rz;
    side_nxt.scaled_x = px[SCALED_W-1:0];
    side_nxt.scaled_y = py[SCALED_W-1:0];
    side_nxt.scaled_z = pz[SCALED_W-1:0];
    side_nxt.zero     = (rx == '0) && (ry == '0);
    if (rx[AXIS_W-1]) begin
      x17            = -$signed({rx[AXIS_W-1], rx});
      y17            = -$signed({ry[AXIS_W-1], ry});
      cordic_nxt.acc = HALF_TURN_ACC;
    end else begin
      x17            = $signed({rx[AXIS_W-1], rx});
      y17            = $signed({ry[AXIS_W-1], ry});
      cordic_nxt.acc = '0;
    end
    cordic_nxt.x = {{(XY_W - AXIS_W - 1 - PRESHIFT){x17[AXIS_W]}}, x17, {PRESHIFT{1'b0}}};
    cordic_nxt.y = {{(XY_W - AXIS_W - 1 - PRESHIFT){y17[AXIS_W]}}, y17, {PRESHIFT{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      side_r   <= side_nxt;
      cordic_r <= cordic_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_side   = side_r;
  assign out_cordic = cordic_r;

endmodule

// File: hw/rtl/maghead_cordic.sv
// CORDIC vectoring pipeline: one rotation step per register stage.
`timescale 1ns / 1ps
module maghead_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  maghead_pkg::side_t   in_side,
  input  maghead_pkg::cordic_t in_cordic,
  output logic                 out_valid,
  input  logic                 out_ready,
  output maghead_pkg::side_t   out_side,
  output maghead_pkg::cordic_t out_cordic
);
  import maghead_pkg::*;

  logic [CORDIC_STEPS-1:0] valid_r;
  logic [CORDIC_STEPS:0]   rdy;
  side_t                   side_r   [CORDIC_STEPS];
  cordic_t                 cordic_r [CORDIC_STEPS];

  assign rdy[CORDIC_STEPS] = out_ready;
  assign in_ready          = rdy[0];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic                   prev_v;
    side_t                  prev_s;
    cordic_t                prev_c;
    cordic_t                c_nxt;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    if (k == 0) begin : g_head
      assign prev_v = in_valid;
      assign prev_s = in_side;
      assign prev_c = in_cordic;
    end else begin : g_body
      assign prev_v = valid_r[k-1];
      assign prev_s = side_r[k-1];
      assign prev_c = cordic_r[k-1];
    end

    assign rdy[k] = !valid_r[k] || rdy[k+1];

    always_comb begin
      xs = prev_c.x >>> k;
      ys = prev_c.y >>> k;
      if (!prev_c.y[XY_W-1] && (prev_c.y != '0)) begin
        c_nxt.x   = prev_c.x + ys;
        c_nxt.y   = prev_c.y - xs;
        c_nxt.acc = prev_c.acc + ATAN_TAB[k];
      end else begin
        c_nxt.x   = prev_c.x - ys;
        c_nxt.y   = prev_c.y + xs;
        c_nxt.acc = prev_c.acc - ATAN_TAB[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_r[k] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && prev_v) begin
        side_r[k]   <= prev_s;
        cordic_r[k] <= c_nxt;
      end
    end
  end

  assign out_valid  = valid_r[CORDIC_STEPS-1];
  assign out_side   = side_r[CORDIC_STEPS-1];
  assign out_cordic = cordic_r[CORDIC_STEPS-1];

endmodule

// File: hw/rtl/maghead_finish.sv
// Output stage: wrap/round the angle (0 if X,Y=0), hold the result.
`timescale 1ns / 1ps
module maghead_finish (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  maghead_pkg::side_t            in_side,
  input  maghead_pkg::cordic_t          in_cordic,
  output logic                          out_valid,
  input  logic                          out_ready,
  output maghead_pkg::side_t            out_side,
  output logic [maghead_pkg::HEAD_W-1:0] out_heading
);
  import maghead_pkg::*;

  logic                  valid_r;
  side_t                 side_r;
  logic [HEAD_W-1:0]     heading_r;
  logic [HEAD_W-1:0]     heading_nxt;
  logic signed [ACC_W:0] acc_w;
  logic signed [ACC_W:0] rnd;
  logic signed [ACC_W:0] wrapped;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    acc_w = {in_cordic.acc[ACC_W-1], in_cordic.acc};
    if (acc_w[ACC_W]) begin
      acc_w = acc_w + FULL_TURN_ACC;
    end
    rnd = (acc_w + ROUND_HALF) >>> ROUND_SHIFT;
    if (rnd >= FULL_TURN_OUT) begin
      wrapped = rnd - FULL_TURN_OUT;
    end else begin
      wrapped = rnd;
    end
    heading_nxt = in_side.zero ? '0 : wrapped[HEAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      side_r    <= in_side;
      heading_r <= heading_nxt;
    end
  end

  assign out_valid   = valid_r;
  assign out_side    = side_r;
  assign out_heading = heading_r;

endmodule
